>>> hdl/brk4_pkg.sv
package brk4_pkg;

   // fixed point format and phase table size
   localparam int FRAC_BITS            = 30;
   localparam int SINE_TABLE_ADDR_BITS = 10;
   localparam int TRIG_SHIFT           = 30;

   localparam int DATA_W      = 32;
   localparam int RATE_W      = 31;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 104;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [DATA_W-1:0] INIT_MZ_RESET = 32'sd1073741824;
   localparam logic signed [DATA_W-1:0] UNIT_VAL      = 32'(64'sd1 <<< FRAC_BITS);

   // quarter-wave sine table, one entry per truncated phase step plus the endpoint
   localparam int SIN_QTR   = 2 ** (SINE_TABLE_ADDR_BITS - 2);
   localparam int SIN_DEPTH = SIN_QTR + 1;
   localparam int SIN_IDX_W = SINE_TABLE_ADDR_BITS - 1;

   localparam longint unsigned Q30ONE = 64'd1 << 30;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam int unsigned TAYLOR_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

   typedef logic [30:0] sin_rom_type [SIN_DEPTH];

   function automatic sin_rom_type sin_rom_init();
      sin_rom_type     rom;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      for (int i = 0; i < SIN_DEPTH; i++) begin
         r  = longint'(i) << (16 - SINE_TABLE_ADDR_BITS);
         x  = (r * PI_Q30) >> 15;
         x2 = (x * x) >> 30;
         t  = Q30ONE;
         for (int k = 0; k < 7; k++) begin
            t = Q30ONE - ((x2 * t) >> 30) / TAYLOR_DIV[k];
         end
         t = (x * t) >> 30;
         if (t > Q30ONE) begin
            t = Q30ONE;
         end
         rom[i] = t[30:0];
      end
      return rom;
   endfunction

   localparam sin_rom_type SIN_ROM = sin_rom_init();

   // division of the weighted stage sum by six, one digit per cycle
   localparam int DIV_BY      = 6;
   localparam int ACC_W       = 36;
   localparam int DIV_DIGIT_W = 6;
   localparam int DIV_STEPS   = 7;
   localparam int DIV_W       = DIV_DIGIT_W * DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int DIV_OFS_EXP = 35;
   localparam logic [DIV_W-1:0] DIV_BIAS =
      DIV_W'(3) + (DIV_W'(DIV_BY) << DIV_OFS_EXP);

   // register file of the datapath
   localparam int RF_DEPTH = 32;

   typedef enum logic [4:0] {
      RA_MX, RA_MY, RA_MZ, RA_BX, RA_BY, RA_BZ, RA_R1, RA_R2, RA_UN, RA_ZR,
      RA_B1, RA_CS, RA_SN, RA_DX, RA_DY, RA_DZ, RA_HX, RA_HY, RA_HZ, RA_FX,
      RA_FY, RA_FZ, RA_T0, RA_T1, RA_CH, RA_CF, RA_K2, RA_K3, RA_K4
   } rf_addr_type;

   typedef enum logic [3:0] {
      OP_LOAD, OP_ADD, OP_SUB, OP_HALF, OP_MUL, OP_MULT, OP_SUMA, OP_SUMB,
      OP_DIV, OP_ADDQ, OP_STX, OP_STY, OP_STZ, OP_END
   } op_type;

   typedef enum logic [3:0] {
      SRC_NONE, SRC_MAG_X, SRC_MAG_Y, SRC_MAG_Z, SRC_OFF, SRC_R1, SRC_R2,
      SRC_UNIT, SRC_ZERO, SRC_B1, SRC_COS, SRC_SIN
   } src_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFF_RES, CSR_RATE_T, CSR_RATE_L, CSR_INIT_MX, CSR_INIT_MY, CSR_INIT_MZ
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MUL_WB, ST_DIV, ST_FINISH
   } state_type;

   typedef struct packed {
      op_type      op;
      rf_addr_type dst;
      rf_addr_type src_a;
      rf_addr_type src_b;
      src_type     src;
   } instr_type;

   typedef struct packed {
      instr_type ins;
      logic      capture;
      logic      restart;
      logic      exec;
      logic      mul_wb;
      logic      div_step;
      logic      load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     clip;
   } sat_type;

   function automatic sat_type sat_val(input logic signed [64:0] v);
      sat_type s;
      s.clip = 1'b1;
      if (v > 65'sd2147483647) begin
         s.val = 32'sh7fffffff;
      end else if (v < -65'sd2147483648) begin
         s.val = 32'sh80000000;
      end else begin
         s.val  = v[DATA_W-1:0];
         s.clip = 1'b0;
      end
      return s;
   endfunction

   function automatic instr_type ld(input rf_addr_type d, input src_type s);
      return '{OP_LOAD, d, RA_MX, RA_MX, s};
   endfunction

   function automatic instr_type ins(input op_type o, input rf_addr_type d,
                                     input rf_addr_type a, input rf_addr_type b);
      return '{o, d, a, b, SRC_NONE};
   endfunction

   // step program: field, first derivative, midpoints, then three component updates
   localparam int PROG_LEN = 115;
   localparam int PC_W     = $clog2(PROG_LEN);
   typedef instr_type prog_type [PROG_LEN];

   localparam prog_type PROG = '{
      ld(RA_MX, SRC_MAG_X), ld(RA_MY, SRC_MAG_Y), ld(RA_MZ, SRC_MAG_Z),
      ld(RA_R1, SRC_R1), ld(RA_R2, SRC_R2), ld(RA_UN, SRC_UNIT),
      ld(RA_ZR, SRC_ZERO), ld(RA_B1, SRC_B1), ld(RA_CS, SRC_COS),
      ld(RA_SN, SRC_SIN), ld(RA_T0, SRC_OFF),
      ins(OP_SUB, RA_BZ, RA_ZR, RA_T0),
      ins(OP_MULT, RA_BX, RA_B1, RA_CS),
      ins(OP_MULT, RA_BY, RA_B1, RA_SN),
      // first stage derivative
      ins(OP_MUL, RA_T0, RA_MY, RA_BZ), ins(OP_MUL, RA_T1, RA_MZ, RA_BY),
      ins(OP_SUB, RA_T0, RA_T0, RA_T1), ins(OP_MUL, RA_T1, RA_R2, RA_MX),
      ins(OP_SUB, RA_DX, RA_T0, RA_T1),
      ins(OP_MUL, RA_T0, RA_MZ, RA_BX), ins(OP_MUL, RA_T1, RA_MX, RA_BZ),
      ins(OP_SUB, RA_T0, RA_T0, RA_T1), ins(OP_MUL, RA_T1, RA_R2, RA_MY),
      ins(OP_SUB, RA_DY, RA_T0, RA_T1),
      ins(OP_MUL, RA_T0, RA_MX, RA_BY), ins(OP_MUL, RA_T1, RA_MY, RA_BX),
      ins(OP_SUB, RA_T0, RA_T0, RA_T1), ins(OP_SUB, RA_T1, RA_MZ, RA_UN),
      ins(OP_MUL, RA_T1, RA_R1, RA_T1), ins(OP_SUB, RA_DZ, RA_T0, RA_T1),
      // half and full step points
      ins(OP_HALF, RA_T0, RA_DX, RA_DX), ins(OP_ADD, RA_HX, RA_MX, RA_T0),
      ins(OP_HALF, RA_T0, RA_DY, RA_DY), ins(OP_ADD, RA_HY, RA_MY, RA_T0),
      ins(OP_HALF, RA_T0, RA_DZ, RA_DZ), ins(OP_ADD, RA_HZ, RA_MZ, RA_T0),
      ins(OP_ADD, RA_FX, RA_MX, RA_DX), ins(OP_ADD, RA_FY, RA_MY, RA_DY),
      ins(OP_ADD, RA_FZ, RA_MZ, RA_DZ),
      // x component
      ins(OP_MUL, RA_T0, RA_HY, RA_BZ), ins(OP_MUL, RA_T1, RA_HZ, RA_BY),
      ins(OP_SUB, RA_CH, RA_T0, RA_T1),
      ins(OP_MUL, RA_T0, RA_FY, RA_BZ), ins(OP_MUL, RA_T1, RA_FZ, RA_BY),
      ins(OP_SUB, RA_CF, RA_T0, RA_T1),
      ins(OP_HALF, RA_T0, RA_DX, RA_DX), ins(OP_ADD, RA_T0, RA_MX, RA_T0),
      ins(OP_SUB, RA_T0, RA_T0, RA_ZR), ins(OP_MUL, RA_T0, RA_R2, RA_T0),
      ins(OP_SUB, RA_K2, RA_CH, RA_T0),
      ins(OP_HALF, RA_T0, RA_K2, RA_K2), ins(OP_ADD, RA_T0, RA_MX, RA_T0),
      ins(OP_SUB, RA_T0, RA_T0, RA_ZR), ins(OP_MUL, RA_T0, RA_R2, RA_T0),
      ins(OP_SUB, RA_K3, RA_CH, RA_T0),
      ins(OP_ADD, RA_T0, RA_MX, RA_K3), ins(OP_SUB, RA_T0, RA_T0, RA_ZR),
      ins(OP_MUL, RA_T0, RA_R2, RA_T0), ins(OP_SUB, RA_K4, RA_CF, RA_T0),
      ins(OP_SUMA, RA_T0, RA_DX, RA_K2), ins(OP_SUMB, RA_T0, RA_K3, RA_K4),
      ins(OP_DIV, RA_T0, RA_T0, RA_T0), ins(OP_ADDQ, RA_MX, RA_MX, RA_MX),
      // y component
      ins(OP_MUL, RA_T0, RA_HZ, RA_BX), ins(OP_MUL, RA_T1, RA_HX, RA_BZ),
      ins(OP_SUB, RA_CH, RA_T0, RA_T1),
      ins(OP_MUL, RA_T0, RA_FZ, RA_BX), ins(OP_MUL, RA_T1, RA_FX, RA_BZ),
      ins(OP_SUB, RA_CF, RA_T0, RA_T1),
      ins(OP_HALF, RA_T0, RA_DY, RA_DY), ins(OP_ADD, RA_T0, RA_MY, RA_T0),
      ins(OP_SUB, RA_T0, RA_T0, RA_ZR), ins(OP_MUL, RA_T0, RA_R2, RA_T0),
      ins(OP_SUB, RA_K2, RA_CH, RA_T0),
      ins(OP_HALF, RA_T0, RA_K2, RA_K2), ins(OP_ADD, RA_T0, RA_MY, RA_T0),
      ins(OP_SUB, RA_T0, RA_T0, RA_ZR), ins(OP_MUL, RA_T0, RA_R2, RA_T0),
      ins(OP_SUB, RA_K3, RA_CH, RA_T0),
      ins(OP_ADD, RA_T0, RA_MY, RA_K3), ins(OP_SUB, RA_T0, RA_T0, RA_ZR),
      ins(OP_MUL, RA_T0, RA_R2, RA_T0), ins(OP_SUB, RA_K4, RA_CF, RA_T0),
      ins(OP_SUMA, RA_T0, RA_DY, RA_K2), ins(OP_SUMB, RA_T0, RA_K3, RA_K4),
      ins(OP_DIV, RA_T0, RA_T0, RA_T0), ins(OP_ADDQ, RA_MY, RA_MY, RA_MY),
      // z component
      ins(OP_MUL, RA_T0, RA_HX, RA_BY), ins(OP_MUL, RA_T1, RA_HY, RA_BX),
      ins(OP_SUB, RA_CH, RA_T0, RA_T1),
      ins(OP_MUL, RA_T0, RA_FX, RA_BY), ins(OP_MUL, RA_T1, RA_FY, RA_BX),
      ins(OP_SUB, RA_CF, RA_T0, RA_T1),
      ins(OP_HALF, RA_T0, RA_DZ, RA_DZ), ins(OP_ADD, RA_T0, RA_MZ, RA_T0),
      ins(OP_SUB, RA_T0, RA_T0, RA_UN), ins(OP_MUL, RA_T0, RA_R1, RA_T0),
      ins(OP_SUB, RA_K2, RA_CH, RA_T0),
      ins(OP_HALF, RA_T0, RA_K2, RA_K2), ins(OP_ADD, RA_T0, RA_MZ, RA_T0),
      ins(OP_SUB, RA_T0, RA_T0, RA_UN), ins(OP_MUL, RA_T0, RA_R1, RA_T0),
      ins(OP_SUB, RA_K3, RA_CH, RA_T0),
      ins(OP_ADD, RA_T0, RA_MZ, RA_K3), ins(OP_SUB, RA_T0, RA_T0, RA_UN),
      ins(OP_MUL, RA_T0, RA_R1, RA_T0), ins(OP_SUB, RA_K4, RA_CF, RA_T0),
      ins(OP_SUMA, RA_T0, RA_DZ, RA_K2), ins(OP_SUMB, RA_T0, RA_K3, RA_K4),
      ins(OP_DIV, RA_T0, RA_T0, RA_T0), ins(OP_ADDQ, RA_MZ, RA_MZ, RA_MZ),
      // write back state
      ins(OP_STX, RA_T0, RA_MX, RA_MX), ins(OP_STY, RA_T0, RA_MY, RA_MY),
      ins(OP_STZ, RA_T0, RA_MZ, RA_MZ), ins(OP_END, RA_T0, RA_T0, RA_T0)
   };

endpackage

>>> hdl/brk4_ctrl.sv
module brk4_ctrl
   import brk4_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_mode,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   state_type             state_ff, state_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   instr_type             cur_ins;

   assign cur_ins    = PROG[pc_ff];
   assign rsp_tvalid = rsp_valid_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencing through the step program
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.ins      = cur_ins;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_mode) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  cmd.capture = 1'b1;
                  pc_in       = '0;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (cur_ins.op)
               OP_MUL, OP_MULT: state_in = ST_MUL_WB;
               OP_DIV: begin
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
               OP_END: state_in = ST_FINISH;
               default: begin
                  pc_in    = pc_ff + PC_W'(1);
                  state_in = ST_READ;
               end
            endcase
         end
         ST_MUL_WB: begin
            cmd.mul_wb = 1'b1;
            pc_in      = pc_ff + PC_W'(1);
            state_in   = ST_READ;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               pc_in    = pc_ff + PC_W'(1);
               state_in = ST_READ;
            end else begin
               cnt_in = cnt_ff + DIV_CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> hdl/brk4_dpath.sv
module brk4_dpath
   import brk4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic signed [DATA_W-1:0] b1_step,
   input  logic [15:0]              rf_phase,
   input  logic                     csr_wen,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   output logic signed [DATA_W-1:0] mag_x,
   output logic signed [DATA_W-1:0] mag_y,
   output logic signed [DATA_W-1:0] mag_z,
   output logic                     saturated
);

   // configuration
   logic signed [DATA_W-1:0] off_ff, init_mx_ff, init_my_ff, init_mz_ff;
   logic [RATE_W-1:0]        rate_t_ff, rate_l_ff;

   // state and item registers
   logic signed [DATA_W-1:0] mag_ff [3];
   logic                     sat_ff;
   logic signed [DATA_W-1:0] b1_ff;
   logic [15:0]              phase_ff;
   logic [30:0]              sin_ff, cos_ff;
   logic [1:0]               quad_ff;

   // register file and operands
   logic signed [DATA_W-1:0] rf_mem [RF_DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [63:0]       prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [2:0]               rem_ff, rem_in;

   logic signed [DATA_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                     out_sat_ff;

   logic [SINE_TABLE_ADDR_BITS-3:0] ridx;
   logic [SIN_IDX_W-1:0]            sin_idx, cos_idx;
   logic signed [DATA_W-1:0]        sr, cr, cval, sval, load_val, wr_data;
   logic                            wr_en, clip;

   assign ridx    = phase_ff[13 -: (SINE_TABLE_ADDR_BITS - 2)];
   assign sin_idx = {1'b0, ridx};
   assign cos_idx = SIN_IDX_W'(SIN_QTR) - {1'b0, ridx};
   assign sr      = {1'b0, sin_ff};
   assign cr      = {1'b0, cos_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff     <= '0;
         rate_t_ff  <= '0;
         rate_l_ff  <= '0;
         init_mx_ff <= '0;
         init_my_ff <= '0;
         init_mz_ff <= INIT_MZ_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_OFF_RES: off_ff     <= csr_wdata;
            CSR_RATE_T:  rate_t_ff  <= csr_wdata[RATE_W-1:0];
            CSR_RATE_L:  rate_l_ff  <= csr_wdata[RATE_W-1:0];
            CSR_INIT_MX: init_mx_ff <= csr_wdata;
            CSR_INIT_MY: init_my_ff <= csr_wdata;
            CSR_INIT_MZ: init_mz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item capture and sine table lookup
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         b1_ff    <= b1_step;
         phase_ff <= rf_phase;
      end
      sin_ff  <= SIN_ROM[sin_idx];
      cos_ff  <= SIN_ROM[cos_idx];
      quad_ff <= phase_ff[15:14];
   end

   // quadrant folding
   always_comb begin
      case (quad_ff)
         2'd0: begin cval = cr;  sval = sr;  end
         2'd1: begin cval = -sr; sval = cr;  end
         2'd2: begin cval = -cr; sval = -sr; end
         default: begin cval = sr; sval = -cr; end
      endcase
   end

   // operand sources for loads
   always_comb begin
      case (cmd.ins.src)
         SRC_MAG_X: load_val = mag_ff[0];
         SRC_MAG_Y: load_val = mag_ff[1];
         SRC_MAG_Z: load_val = mag_ff[2];
         SRC_OFF:   load_val = off_ff;
         SRC_R1:    load_val = {1'b0, rate_l_ff};
         SRC_R2:    load_val = {1'b0, rate_t_ff};
         SRC_UNIT:  load_val = UNIT_VAL;
         SRC_B1:    load_val = b1_ff;
         SRC_COS:   load_val = cval;
         SRC_SIN:   load_val = sval;
         default:   load_val = '0;
      endcase
   end

   // alu and multiplier writeback with rounding and saturation
   always_comb begin
      logic signed [64:0] ea;
      logic signed [64:0] eb;
      logic signed [64:0] tmp;
      logic signed [64:0] qv;
      sat_type            s;
      ea      = 65'(rd_a_ff);
      eb      = 65'(rd_b_ff);
      qv      = 65'(signed'({1'b0, div_ff}));
      tmp     = '0;
      s       = '0;
      wr_en   = 1'b0;
      wr_data = '0;
      clip    = 1'b0;
      if (cmd.exec) begin
         case (cmd.ins.op)
            OP_LOAD: begin
               wr_en   = 1'b1;
               wr_data = load_val;
            end
            OP_ADD: begin
               s       = sat_val(ea + eb);
               wr_en   = 1'b1;
               wr_data = s.val;
               clip    = s.clip;
            end
            OP_SUB: begin
               s       = sat_val(ea - eb);
               wr_en   = 1'b1;
               wr_data = s.val;
               clip    = s.clip;
            end
            OP_HALF: begin
               tmp     = (ea + 65'sd1) >>> 1;
               wr_en   = 1'b1;
               wr_data = tmp[DATA_W-1:0];
            end
            OP_ADDQ: begin
               s       = sat_val(ea + qv - (65'sd1 <<< DIV_OFS_EXP));
               wr_en   = 1'b1;
               wr_data = s.val;
               clip    = s.clip;
            end
            default: ;
         endcase
      end
      if (cmd.mul_wb) begin
         if (cmd.ins.op == OP_MULT) begin
            tmp = (65'(prod_ff) + (65'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
         end else begin
            tmp = (65'(prod_ff) + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         end
         s       = sat_val(tmp);
         wr_en   = 1'b1;
         wr_data = s.val;
         clip    = s.clip;
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[cmd.ins.dst] <= wr_data;
      end
      rd_a_ff <= rf_mem[cmd.ins.src_a];
      rd_b_ff <= rf_mem[cmd.ins.src_b];
   end

   // radix-64 digit step of the divide by six
   always_comb begin
      logic [2:0]             rv;
      logic [3:0]             r4;
      logic [DIV_DIGIT_W-1:0] qd;
      rv = rem_ff;
      r4 = '0;
      qd = '0;
      for (int j = 0; j < DIV_DIGIT_W; j++) begin
         r4 = {rv, div_ff[DIV_W-1-j]};
         if (r4 >= 4'(DIV_BY)) begin
            qd[DIV_DIGIT_W-1-j] = 1'b1;
            rv = 3'(r4 - 4'(DIV_BY));
         end else begin
            rv = r4[2:0];
         end
      end
      rem_in = rv;
      div_in = {div_ff[DIV_W-DIV_DIGIT_W-1:0], qd};
   end

   // multiplier, stage sum and divider
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         case (cmd.ins.op)
            OP_MUL, OP_MULT: prod_ff <= rd_a_ff * rd_b_ff;
            OP_SUMA: acc_ff <= ACC_W'(rd_a_ff) + (ACC_W'(rd_b_ff) <<< 1);
            OP_SUMB: acc_ff <= acc_ff + (ACC_W'(rd_a_ff) <<< 1) + ACC_W'(rd_b_ff);
            OP_DIV: begin
               div_ff <= DIV_W'(acc_ff) + DIV_BIAS;
               rem_ff <= '0;
            end
            default: ;
         endcase
      end else if (cmd.div_step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
   end

   // magnetization state and clip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff[0] <= '0;
         mag_ff[1] <= '0;
         mag_ff[2] <= INIT_MZ_RESET;
         sat_ff    <= 1'b0;
      end else begin
         if (cmd.restart) begin
            mag_ff[0] <= init_mx_ff;
            mag_ff[1] <= init_my_ff;
            mag_ff[2] <= init_mz_ff;
         end else if (cmd.exec && cmd.ins.op == OP_STX) begin
            mag_ff[0] <= rd_a_ff;
         end else if (cmd.exec && cmd.ins.op == OP_STY) begin
            mag_ff[1] <= rd_a_ff;
         end else if (cmd.exec && cmd.ins.op == OP_STZ) begin
            mag_ff[2] <= rd_a_ff;
         end
         if (cmd.restart || cmd.capture) begin
            sat_ff <= 1'b0;
         end else if (clip) begin
            sat_ff <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_x_ff   <= mag_ff[0];
         out_y_ff   <= mag_ff[1];
         out_z_ff   <= mag_ff[2];
         out_sat_ff <= sat_ff;
      end
   end

   assign mag_x     = out_x_ff;
   assign mag_y     = out_y_ff;
   assign mag_z     = out_z_ff;
   assign saturated = out_sat_ff;

endmodule

>>> hdl/bloch_rk4_step_unit.sv
// Bloch equation stepper: advances one magnetization vector by one RF sample
// per request with a four-stage Runge-Kutta update in Q2.30 fixed point.
// Request channel (req_): tdata carries b1_step and rf_phase, tuser is the
// mode bit (0 advance, 1 restart from the init_m* registers).
// Response channel (rsp_): one transfer per request with mag_x, mag_y, mag_z
// and the saturated flag.
// Configuration (csr_): a write of csr_wdata to register csr_index whenever
// csr_wen is high; write only while no request is in flight.
// Sequencing: a restart goes from acceptance through ST_FINISH to the response.
// An advance runs a 115-instruction program on one shared multiplier and a
// register file: each instruction passes ST_READ and ST_EXEC, a multiply adds
// ST_MUL_WB and a divide by six adds the ST_DIV digit steps. One request is
// worked on at a time; the next is accepted in the cycle after the response is
// loaded.
// Reset clears the configuration to its defaults and the state to (0, 0, 1.0).
// If the receiver stalls, the result waits in the response register and the
// next request is still accepted; its result loads once that one is taken.
module bloch_rk4_step_unit
   import brk4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // b1_step[31:0], rf_phase[47:32]
   input  logic                   req_tuser,   // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // mag_x, mag_y, mag_z, saturated, zero pad
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   dp_cmd_type               cmd;
   logic signed [DATA_W-1:0] mag_x, mag_y, mag_z;
   logic                     saturated;

   // sequencer
   brk4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // arithmetic and state
   brk4_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .b1_step   (req_tdata[31:0]),
      .rf_phase  (req_tdata[47:32]),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mag_x     (mag_x),
      .mag_y     (mag_y),
      .mag_z     (mag_z),
      .saturated (saturated)
   );

   assign rsp_tdata = {7'd0, saturated, mag_z, mag_y, mag_x};

endmodule

>>> bench/bloch_rk4_step_unit_tb.sv
module bloch_rk4_step_unit_tb;
   import brk4_pkg::*;

   typedef struct {
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [31:0] mz;
      logic               sat;
   } mag_result_t;

   typedef struct {
      logic               mode;
      logic signed [31:0] b1;
      logic [15:0]        phase;
      logic               typed;
      mag_result_t        res;
   } stim_row_t;

   localparam longint MAXV      = 64'sd2147483647;
   localparam longint MINV      = -64'sd2147483648;
   localparam longint ONE_Q     = 64'sd1 <<< FRAC_BITS;
   localparam int     WDOG_MAX  = 20000;
   localparam int     N_PHASES  = 4;
   localparam int     PHASE_LEN = 400;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_wdata;

   bloch_rk4_step_unit uut (.*);

   // predictor state and configuration copy
   longint      mag_st [3];
   longint      off_res, rate_t, rate_l, init_x, init_y, init_z;
   bit          clip_seen;
   mag_result_t mag_expect_q [$];
   int          fail_count;
   int          idle_pct;
   int          stall_pct;
   bit          cur_typed;
   mag_result_t cur_res;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fixed point helpers
   function automatic longint clip32(longint v);
      if (v > MAXV) begin
         clip_seen = 1'b1;
         return MAXV;
      end
      if (v < MINV) begin
         clip_seen = 1'b1;
         return MINV;
      end
      return v;
   endfunction

   function automatic longint round_shift(longint p, int sh);
      return (p + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return clip32(round_shift(a * b, FRAC_BITS));
   endfunction

   function automatic longint fx_add(longint a, longint b);
      return clip32(a + b);
   endfunction

   function automatic longint fx_sub(longint a, longint b);
      return clip32(a - b);
   endfunction

   function automatic longint fx_half(longint a);
      return round_shift(a, 1);
   endfunction

   function automatic longint div_by6(longint s);
      longint x;
      x = s + 3;
      if (x >= 0) return x / 6;
      return -((-x + 5) / 6);
   endfunction

   // sine over a quarter turn, taylor series in Q1.30
   function automatic longint quarter_sine(longint unsigned r);
      longint unsigned one_q30;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned dv [7];
      dv = '{210, 156, 110, 72, 42, 20, 6};
      one_q30 = 64'd1 << 30;
      x = (r * 64'd3373259426) >> 15;
      x2 = (x * x) >> 30;
      t = one_q30;
      for (int i = 0; i < 7; i++) t = one_q30 - ((x2 * t) >> 30) / dv[i];
      t = (x * t) >> 30;
      if (t > one_q30) t = one_q30;
      return longint'(t);
   endfunction

   // one runge-kutta component update, stages two to four
   function automatic longint rk_component(longint m, longint k1, longint ch, longint cf,
                                           longint rate, longint ofs);
      longint k2, k3, k4;
      k2 = fx_sub(ch, fx_mul(rate, fx_sub(fx_add(m, fx_half(k1)), ofs)));
      k3 = fx_sub(ch, fx_mul(rate, fx_sub(fx_add(m, fx_half(k2)), ofs)));
      k4 = fx_sub(cf, fx_mul(rate, fx_sub(fx_add(m, k3), ofs)));
      return fx_add(m, div_by6(k1 + 2 * k2 + 2 * k3 + k4));
   endfunction

   // next magnetization for one request
   function automatic mag_result_t bloch_step(logic mode, logic signed [31:0] b1_in,
                                              logic [15:0] phase);
      mag_result_t r;
      longint mx, my, mz, b1, c, s, sr, cr, bx, by, bz;
      longint dx, dy, dz, hx, hy, hz, fx, fy, fz;
      int unsigned p, quad, rem;
      clip_seen = 1'b0;
      if (mode) begin
         mag_st[0] = init_x;
         mag_st[1] = init_y;
         mag_st[2] = init_z;
      end else begin
         mx = mag_st[0];
         my = mag_st[1];
         mz = mag_st[2];
         b1 = longint'(b1_in);
         p = (int'(phase) >> (16 - SINE_TABLE_ADDR_BITS)) << (16 - SINE_TABLE_ADDR_BITS);
         quad = (p >> 14) & 3;
         rem = p & 16'h3fff;
         sr = quarter_sine(rem);
         cr = quarter_sine(16384 - rem);
         case (quad)
            0: begin c = cr;  s = sr;  end
            1: begin c = -sr; s = cr;  end
            2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
         endcase
         bx = clip32(round_shift(b1 * c, 30));
         by = clip32(round_shift(b1 * s, 30));
         bz = clip32(-off_res);
         dx = fx_sub(fx_sub(fx_mul(my, bz), fx_mul(mz, by)), fx_mul(rate_t, mx));
         dy = fx_sub(fx_sub(fx_mul(mz, bx), fx_mul(mx, bz)), fx_mul(rate_t, my));
         dz = fx_sub(fx_sub(fx_mul(mx, by), fx_mul(my, bx)),
                     fx_mul(rate_l, fx_sub(mz, ONE_Q)));
         hx = fx_add(mx, fx_half(dx));
         hy = fx_add(my, fx_half(dy));
         hz = fx_add(mz, fx_half(dz));
         fx = fx_add(mx, dx);
         fy = fx_add(my, dy);
         fz = fx_add(mz, dz);
         mag_st[0] = rk_component(mx, dx, fx_sub(fx_mul(hy, bz), fx_mul(hz, by)),
                                  fx_sub(fx_mul(fy, bz), fx_mul(fz, by)), rate_t, 0);
         mag_st[1] = rk_component(my, dy, fx_sub(fx_mul(hz, bx), fx_mul(hx, bz)),
                                  fx_sub(fx_mul(fz, bx), fx_mul(fx, bz)), rate_t, 0);
         mag_st[2] = rk_component(mz, dz, fx_sub(fx_mul(hx, by), fx_mul(hy, bx)),
                                  fx_sub(fx_mul(fx, by), fx_mul(fy, bx)), rate_l, ONE_Q);
      end
      r.mx = mag_st[0][31:0];
      r.my = mag_st[1][31:0];
      r.mz = mag_st[2][31:0];
      r.sat = clip_seen;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // predictor updates on transfers, checker on responses
   always @(posedge clock) begin
      mag_result_t e;
      if (reset) begin
         off_res = 0;
         rate_t = 0;
         rate_l = 0;
         init_x = 0;
         init_y = 0;
         init_z = ONE_Q;
         mag_st = '{0, 0, ONE_Q};
      end else begin
         if (csr_wen) begin
            case (csr_index_type'(csr_index))
               CSR_OFF_RES: off_res = longint'($signed(csr_wdata));
               CSR_RATE_T:  rate_t = longint'(csr_wdata[30:0]);
               CSR_RATE_L:  rate_l = longint'(csr_wdata[30:0]);
               CSR_INIT_MX: init_x = longint'($signed(csr_wdata));
               CSR_INIT_MY: init_y = longint'($signed(csr_wdata));
               CSR_INIT_MZ: init_z = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            e = bloch_step(req_tuser, req_tdata[31:0], req_tdata[47:32]);
            mag_expect_q.push_back(cur_typed ? cur_res : e);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (mag_expect_q.size() == 0) begin
               $display("unexpected response transfer at %0t", $realtime);
               fail_count++;
            end else begin
               e = mag_expect_q.pop_front();
               if ($signed(rsp_tdata[31:0]) != e.mx)
                  report_mismatch("mag_x", $signed(rsp_tdata[31:0]), e.mx);
               if ($signed(rsp_tdata[63:32]) != e.my)
                  report_mismatch("mag_y", $signed(rsp_tdata[63:32]), e.my);
               if ($signed(rsp_tdata[95:64]) != e.mz)
                  report_mismatch("mag_z", $signed(rsp_tdata[95:64]), e.mz);
               if (rsp_tdata[96] != e.sat)
                  report_mismatch("saturated", rsp_tdata[96], e.sat);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic send_sample(logic mode, logic [31:0] b1, logic [15:0] phase, logic typed,
                              mag_result_t res);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {phase, b1};
      cur_typed = typed;
      cur_res   = res;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mag_expect_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_b1();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(32'h3ff_ffff)) - 32'sh200_0000);
         default: return 32'($signed($urandom_range(32'h7f_ffff)) - 32'sh40_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(3))
         0: return 0;
         1: return $urandom_range(32'h4000_0000);
         default: return $urandom_range(32'h00ff_ffff);
      endcase
   endfunction

   function automatic logic [31:0] pick_mag();
      if ($urandom_range(3) == 0) return $urandom;
      return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
   endfunction

   stim_row_t directed [] = '{
      '{1'b1, 32'sd0, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 32'sd1073741824, 1'b0}},
      '{1'b0, 32'sd0, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 32'sd1073741824, 1'b0}},
      '{1'b0, 32'sh7fffffff, 16'h0000, 1'b0, '{0, 0, 0, 0}},
      '{1'b1, 32'sh12345678, 16'hffff, 1'b1, '{32'sd0, 32'sd0, 32'sd1073741824, 1'b0}},
      '{1'b0, 32'sh80000000, 16'h4000, 1'b0, '{0, 0, 0, 0}},
      '{1'b1, 32'sd0, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 32'sd1073741824, 1'b0}},
      '{1'b0, 32'sh00100000, 16'h8000, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'sh00100000, 16'hc000, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'sh00100000, 16'hffff, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'sh00100000, 16'h003f, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'sh00100000, 16'h0040, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, -32'sh00100000, 16'h2000, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'sh40000000, 16'h6000, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'shc0000000, 16'ha000, 1'b0, '{0, 0, 0, 0}},
      '{1'b0, 32'sh00000001, 16'h7fff, 1'b0, '{0, 0, 0, 0}}
   };

   initial begin
      mag_result_t none;
      logic [31:0] cfg [6];
      none = '{0, 0, 0, 0};
      fail_count = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      cur_typed = 1'b0;
      cur_res = none;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows under reset configuration
      foreach (directed[i])
         send_sample(directed[i].mode, directed[i].b1, directed[i].phase,
                     directed[i].typed, directed[i].res);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain_results();
         case (ph)
            0: cfg = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                       32'h8000_0000, 32'h0};
            1: cfg = '{32'h7fff_ffff, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'h4000_0000};
            default: begin
               cfg[0] = ($urandom_range(1) == 0) ? $urandom
                        : 32'($signed($urandom_range(32'h1f_ffff)) - 32'sh10_0000);
               cfg[1] = pick_rate();
               cfg[2] = pick_rate();
               cfg[3] = pick_mag();
               cfg[4] = pick_mag();
               cfg[5] = pick_mag();
            end
         endcase
         for (int k = 0; k < 6; k++) csr_write(csr_index_type'(k), cfg[k]);
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         send_sample(1'b1, $urandom, 16'($urandom), 1'b0, none);
         for (int n = 0; n < PHASE_LEN; n++) begin
            // hold off until the pipeline is empty once per phase
            if (n == PHASE_LEN / 2) drain_results();
            send_sample($urandom_range(99) < 4, pick_b1(), 16'($urandom), 1'b0, none);
         end
      end

      drain_results();
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
